// File: rtl/apfp_pkg.sv
package apfp_pkg;

  localparam int LINE_BUFFER_SIZE = 32;
  localparam int CountW = $clog2(LINE_BUFFER_SIZE);
  localparam logic [CountW-1:0] CountLast = CountW'(LINE_BUFFER_SIZE - 1);

  localparam logic [14:0] PosMax = 15'd32767;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChX     = 8'h58;

  typedef enum logic [3:0] {
    PH_X, PH_XCOLON, PH_XFIRST, PH_XDASH, PH_XNUM, PH_XNONE,
    PH_T, PH_TCOLON, PH_TLEAD, PH_TDIG, PH_TSKIP,
    PH_D, PH_DCOLON, PH_DVAL, PH_DONE, PH_FAIL
  } phase_t;

  typedef enum logic [1:0] {
    FR_INT, FR_POINT, FR_KEPT, FR_STOP
  } frac_t;

  typedef struct packed {
    logic [CountW-1:0] char_count;
    phase_t            parse_phase;
    logic              string_ended;
    logic              value_negative;
    logic [14:0]       value_accum;
    frac_t             fraction_state;
    logic              tentative_seen;
    logic              tick_negative;
    logic [31:0]       tick_accum;
  } line_st_t;

  typedef struct packed {
    logic result;
    logic frame_ok;
  } step_flags_t;

  localparam line_st_t LineRestart = '{
    char_count:     '0,
    parse_phase:    PH_X,
    string_ended:   1'b0,
    value_negative: 1'b0,
    value_accum:    '0,
    fraction_state: FR_INT,
    tentative_seen: 1'b0,
    tick_negative:  1'b0,
    tick_accum:     '0
  };

endpackage

// File: rtl/apfp_step.sv
module apfp_step (
  input  apfp_pkg::line_st_t    st,
  input  logic [7:0]            data_byte,
  output apfp_pkg::line_st_t    st_next,
  output apfp_pkg::step_flags_t flags
);
  import apfp_pkg::*;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // position digits: integer part scaled to tenths, one fraction digit kept
  function automatic line_st_t number_byte(input line_st_t s, input logic [7:0] c);
    line_st_t    r;
    logic        dig;
    logic [15:0] sum;
    logic [18:0] prod;
    r    = s;
    dig  = is_digit(c);
    sum  = {1'b0, s.value_accum} + {12'd0, c[3:0]};
    prod = {sum, 3'b000} + {2'b00, sum, 1'b0};
    if (c == ChComma) begin
      r.parse_phase = PH_T;
    end else begin
      unique case (s.fraction_state)
        FR_INT: begin
          if (dig) begin
            r.value_accum = (prod > 19'(PosMax)) ? PosMax : prod[14:0];
          end else begin
            r.fraction_state = (c == ChDot) ? FR_POINT : FR_STOP;
          end
        end
        FR_POINT: begin
          if (dig) begin
            r.value_accum    = (sum > 16'(PosMax)) ? PosMax : sum[14:0];
            r.fraction_state = FR_KEPT;
          end else begin
            r.fraction_state = FR_STOP;
          end
        end
        FR_KEPT: begin
          if (!dig) r.fraction_state = FR_STOP;
        end
        FR_STOP: begin
        end
      endcase
    end
    return r;
  endfunction

  line_st_t    p;
  logic        dig;
  logic [31:0] tick_x10;

  assign dig      = is_digit(data_byte);
  assign tick_x10 = {st.tick_accum[28:0], 3'b000} + {st.tick_accum[30:0], 1'b0}
                    + {28'd0, data_byte[3:0]};

  // one byte through the field parser
  always_comb begin
    p = st;
    unique case (st.parse_phase)
      PH_X:      p.parse_phase = (data_byte == ChX) ? PH_XCOLON : PH_FAIL;
      PH_XCOLON: p.parse_phase = (data_byte == ChColon) ? PH_XFIRST : PH_FAIL;
      PH_XFIRST: begin
        if (data_byte == ChMinus) begin
          p.value_negative = 1'b1;
          p.tentative_seen = 1'b1;
          p.parse_phase    = PH_XDASH;
        end else if (data_byte == ChPlus) begin
          p.tentative_seen = 1'b1;
          p.parse_phase    = PH_XNUM;
        end else begin
          p.parse_phase = PH_FAIL;
        end
      end
      PH_XDASH: begin
        if (data_byte == ChMinus) begin
          p.tentative_seen = 1'b0;
          p.value_negative = 1'b0;
          p.parse_phase    = PH_XNONE;
        end else begin
          p             = st;
          p.parse_phase = PH_XNUM;
          p             = number_byte(p, data_byte);
        end
      end
      PH_XNUM:   p = number_byte(st, data_byte);
      PH_XNONE:  p.parse_phase = (data_byte == ChComma) ? PH_T : PH_FAIL;
      PH_T:      p.parse_phase = (data_byte == ChT) ? PH_TCOLON : PH_FAIL;
      PH_TCOLON: p.parse_phase = (data_byte == ChColon) ? PH_TLEAD : PH_FAIL;
      PH_TLEAD: begin
        if (data_byte == ChSpace || data_byte == ChTab ||
            data_byte == ChVt || data_byte == ChFf) begin
          // leading blank
        end else if (data_byte == ChPlus || data_byte == ChMinus) begin
          p.tick_negative = (data_byte == ChMinus);
          p.parse_phase   = PH_TDIG;
        end else if (dig) begin
          p.tick_accum  = {28'd0, data_byte[3:0]};
          p.parse_phase = PH_TDIG;
        end else begin
          p.parse_phase = (data_byte == ChComma) ? PH_D : PH_TSKIP;
        end
      end
      PH_TDIG: begin
        if (dig) p.tick_accum = tick_x10;
        else     p.parse_phase = (data_byte == ChComma) ? PH_D : PH_TSKIP;
      end
      PH_TSKIP:  if (data_byte == ChComma) p.parse_phase = PH_D;
      PH_D:      p.parse_phase = (data_byte == ChD) ? PH_DCOLON : PH_FAIL;
      PH_DCOLON: p.parse_phase = (data_byte == ChColon) ? PH_DVAL : PH_FAIL;
      PH_DVAL:   p.parse_phase = ((data_byte == ChOne) == st.tentative_seen) ?
                                 PH_DONE : PH_FAIL;
      PH_DONE, PH_FAIL: begin
      end
    endcase
  end

  // line bookkeeping around the parser
  always_comb begin
    st_next        = st;
    flags.result   = 1'b0;
    flags.frame_ok = (st.parse_phase == PH_DONE) ||
                     (st.parse_phase == PH_DVAL && !st.tentative_seen);
    if (data_byte == ChCr) begin
      st_next = st;
    end else if (data_byte == ChLf) begin
      if (st.char_count != '0) begin
        flags.result = 1'b1;
        st_next      = LineRestart;
      end
    end else if (st.char_count >= CountLast) begin
      st_next = LineRestart;
    end else if (st.string_ended) begin
      st_next            = st;
      st_next.char_count = st.char_count + 1'b1;
    end else if (data_byte == ChNul) begin
      st_next              = st;
      st_next.char_count   = st.char_count + 1'b1;
      st_next.string_ended = 1'b1;
    end else begin
      st_next            = p;
      st_next.char_count = st.char_count + 1'b1;
    end
  end

endmodule

// File: rtl/ascii_position_frame_parser_core.sv
// Position frame line parser.
// Input channel (in_valid/in_ready): one received byte per item with the
// local tick at its arrival. Lines look like X:<pos|-->,T:<ticks>,D:<0|1>;
// carriage returns are skipped and a line feed closes a non-empty line.
// Output channel (out_valid/out_ready): one item per closed line, carrying
// frame_valid and the values held from the last valid frame.
// Throughput: one byte per cycle unless a line feed stalls; the whole
// per-byte parse step sits between the input register and the line
// state / result registers, so a line feed's result is loaded into
// the output register as that line feed leaves the input register.
// Stall: a finished result waits in the output register; bytes that give
// no result keep flowing, and a line feed waits in the input register
// until the result ahead of it is taken, holding in_ready low meanwhile.
// Reset (synchronous, rst high): line state cleared to the start of a
// line, held values zero, both channels empty.
module ascii_position_frame_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic [31:0] now_tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_valid,
  output logic        ball_seen,
  output logic signed [15:0] position_tenths,
  output logic [31:0] remote_tick,
  output logic [31:0] local_tick
);
  import apfp_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic [31:0] s1_tick;
  logic        s1_fire;

  line_st_t    st;
  line_st_t    st_next;
  step_flags_t flags;

  logic [15:0] mag;

  apfp_step u_step (
    .st        (st),
    .data_byte (s1_byte),
    .st_next   (st_next),
    .flags     (flags)
  );

  assign s1_fire  = s1_valid && (!flags.result || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign mag      = {1'b0, st.value_accum};

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_tick <= now_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      st              <= LineRestart;
      out_valid       <= 1'b0;
      frame_valid     <= 1'b0;
      ball_seen       <= 1'b0;
      position_tenths <= '0;
      remote_tick     <= '0;
      local_tick      <= '0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s1_fire) st <= st_next;
      if (s1_fire && flags.result) begin
        out_valid   <= 1'b1;
        frame_valid <= flags.frame_ok;
        if (flags.frame_ok) begin
          // stored position is the negated reading
          position_tenths <= st.value_negative ? mag : (16'd0 - mag);
          ball_seen       <= st.tentative_seen;
          remote_tick     <= st.tick_negative ? (32'd0 - st.tick_accum) : st.tick_accum;
          local_tick      <= s1_tick;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    st.char_count <= CountLast)
    else $error("line byte count past buffer limit");

  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    s1_fire && flags.result |=> out_valid)
    else $error("finished line gave no result");

  a_restart_after_lf: assert property (@(posedge clk) disable iff (rst)
    s1_fire && flags.result |=> st.char_count == '0 && st.parse_phase == PH_X)
    else $error("line state not restarted after line feed");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_byte))
    else $error("stalled byte lost from input register");

  a_ended_nonempty: assert property (@(posedge clk) disable iff (rst)
    st.string_ended |-> st.char_count != '0)
    else $error("string end marked on empty line");

endmodule
